### design/hvd_pkg.sv
// ---------------------------------------------------------------------------
// Haversine distance package
// Shared widths, constants, the CORDIC arctangent table and the queue word type.
// ---------------------------------------------------------------------------
package hvd_pkg;

	localparam int unsigned CORDIC_STEPS = 28;
	localparam int unsigned ROOT_BITS    = 31;
	localparam int unsigned QUEUE_DEPTH  = 8;

	localparam int unsigned SINCOS_LAT = CORDIC_STEPS + 2;
	localparam int unsigned ISQRT_LAT  = ROOT_BITS + 1;
	localparam int unsigned BACK_LAT   = SINCOS_LAT + 4 + ISQRT_LAT + CORDIC_STEPS + 2;

	localparam int unsigned IN_DATA_W  = 104;
	localparam int unsigned OUT_DATA_W = 32;
	localparam int unsigned DIST_W     = 30;

	localparam logic signed [32:0] DEG_TO_PHASE    = 33'sd3054198966;
	localparam logic signed [32:0] CORDIC_INV_GAIN = 33'sd652032874;
	localparam logic [31:0]        DIST_SCALE      = 32'd3260231057;
	localparam logic [29:0]        DIST_MAX        = 30'd815057764;

	// Four phases, one full turn is 2^32.
	typedef struct packed {
		logic [31:0] p_latb;
		logic [31:0] p_lata;
		logic [31:0] p_dlon;
		logic [31:0] p_dlat;
	} phase_set_t;

	function automatic logic [29:0] atan_phase(input int unsigned idx);
		logic [29:0] r;
		case (idx)
			0: r = 30'd536870912;
			1: r = 30'd316933406;
			2: r = 30'd167458907;
			3: r = 30'd85004756;
			4: r = 30'd42667331;
			5: r = 30'd21354465;
			6: r = 30'd10679838;
			7: r = 30'd5340245;
			8: r = 30'd2670163;
			9: r = 30'd1335087;
			10: r = 30'd667544;
			11: r = 30'd333772;
			12: r = 30'd166886;
			13: r = 30'd83443;
			14: r = 30'd41722;
			15: r = 30'd20861;
			16: r = 30'd10430;
			17: r = 30'd5215;
			18: r = 30'd2608;
			19: r = 30'd1304;
			20: r = 30'd652;
			21: r = 30'd326;
			22: r = 30'd163;
			23: r = 30'd81;
			24: r = 30'd41;
			25: r = 30'd20;
			26: r = 30'd10;
			27: r = 30'd5;
			default: r = 30'd0;
		endcase
		return r;
	endfunction

endpackage

### design/haversine_distance_core.sv
// ---------------------------------------------------------------------------
// Haversine distance core
// Great-circle distance in miles between two points given in degrees.
// ---------------------------------------------------------------------------
// Input channel s_axis: one word carries two points, latitude and longitude
// in signed degrees with 16 fraction bits. Output channel m_axis: one word
// per input word, the distance in miles, unsigned with 16 fraction bits,
// saturating at half the circumference.
// The front part turns coordinates into phase angles and writes them to a
// small queue; the back part reads the queue and runs four CORDIC rotations,
// the haversine products, two pipelined square roots, a CORDIC vectoring
// stage and the final scaling. An accepted word passes through the front
// part, the queue and the back pipeline, whose depth is set by the 28-step
// CORDIC pipelines and the 31-digit square roots. Throughput is one word per
// cycle while the receiver is ready. When m_axis_tvalid is high and
// m_axis_tready is low the whole back pipeline holds; the queue absorbs
// the front part's words and s_axis_tready falls once the queue has no room
// for the words still in the front part.
// Reset clears the valid bits, queue pointers and queue count; nothing else is kept.
// ---------------------------------------------------------------------------
module haversine_distance_core #(
	parameter int unsigned QUEUE_DEPTH = hvd_pkg::QUEUE_DEPTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// lat_a[23:0], lon_a[48:24], lat_b[72:49], lon_b[97:73], zero pad
	input  logic [hvd_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// distance_miles[29:0], zero pad
	output logic [hvd_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

	logic push, pop, queue_empty;
	hvd_pkg::phase_set_t push_data, head;
	logic [CW-1:0] queue_count;
	logic [hvd_pkg::DIST_W-1:0] distance;

	hvd_front #(.DEPTH(QUEUE_DEPTH)) u_front (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_axis_tvalid), .s_tready(s_axis_tready), .s_tdata(s_axis_tdata),
		.queue_count(queue_count), .push(push), .push_data(push_data)
	);

	hvd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(push), .push_data(push_data), .pop(pop),
		.head(head), .empty(queue_empty), .count(queue_count)
	);

	hvd_back u_back (
		.clk(clk), .arst_n(arst_n),
		.queue_empty(queue_empty), .head(head), .pop(pop),
		.m_tvalid(m_axis_tvalid), .m_tready(m_axis_tready), .distance(distance)
	);

	assign m_axis_tdata = {{(hvd_pkg::OUT_DATA_W - hvd_pkg::DIST_W){1'b0}}, distance};

	// The front part must never write a full queue.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |-> queue_count < CW'(QUEUE_DEPTH))
		else $error("phase queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !queue_empty)
		else $error("phase queue read while empty");

	a_dist_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[hvd_pkg::DIST_W-1:0] <= hvd_pkg::DIST_MAX)
		else $error("distance above half circumference");

endmodule

### design/hvd_queue.sv
// ---------------------------------------------------------------------------
// Haversine phase queue
// Small register-file FIFO between the front and back parts.
// ---------------------------------------------------------------------------
module hvd_queue #(
	parameter int unsigned DEPTH = hvd_pkg::QUEUE_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  hvd_pkg::phase_set_t        push_data,
	input  logic                       pop,
	output hvd_pkg::phase_set_t        head,
	output logic                       empty,
	output logic [$clog2(DEPTH+1)-1:0] count
);
	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	hvd_pkg::phase_set_t mem_q [0:DEPTH-1];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign head  = mem_q[rd_ptr_q];
	assign empty = (count_q == '0);
	assign count = count_q;

endmodule

### design/hvd_front.sv
// ---------------------------------------------------------------------------
// Haversine front end
// Accepts coordinate words and turns them into four phase angles.
// ---------------------------------------------------------------------------
module hvd_front #(
	parameter int unsigned DEPTH = hvd_pkg::QUEUE_DEPTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [hvd_pkg::IN_DATA_W-1:0]       s_tdata,
	input  logic [$clog2(DEPTH+1)-1:0]          queue_count,
	output logic                                push,
	output hvd_pkg::phase_set_t                 push_data
);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [23:0] lat_a, lat_b;
	logic [24:0] lon_a, lon_b;
	logic signed [25:0] dlat_s1, dlon_s1, lata_s1, latb_s1;
	logic signed [59:0] pdlat_s2, pdlon_s2, plata_s2, platb_s2;
	logic signed [59:0] rdlat, rdlon, rlata, rlatb;
	logic vld_s1, vld_s2;
	logic accept;
	logic [CW:0] occupancy;

	assign lat_a = s_tdata[23:0];
	assign lon_a = s_tdata[48:24];
	assign lat_b = s_tdata[72:49];
	assign lon_b = s_tdata[97:73];

	// Words in flight here always reach the queue, so room is reserved for them.
	assign occupancy = {1'b0, queue_count} + (CW+1)'(vld_s1) + (CW+1)'(vld_s2);
	assign s_tready  = (occupancy < (CW+1)'(DEPTH));
	assign accept    = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		dlat_s1 <= {{2{lat_b[23]}}, lat_b} - {{2{lat_a[23]}}, lat_a};
		dlon_s1 <= {lon_b[24], lon_b} - {lon_a[24], lon_a};
		lata_s1 <= {{2{lat_a[23]}}, lat_a};
		latb_s1 <= {{2{lat_b[23]}}, lat_b};
		pdlat_s2 <= 60'(dlat_s1 * hvd_pkg::DEG_TO_PHASE);
		pdlon_s2 <= 60'(dlon_s1 * hvd_pkg::DEG_TO_PHASE);
		plata_s2 <= 60'(lata_s1 * hvd_pkg::DEG_TO_PHASE);
		platb_s2 <= 60'(latb_s1 * hvd_pkg::DEG_TO_PHASE);
	end

	// Half differences take one more bit of shift than the plain latitudes.
	assign rdlat = pdlat_s2 + (60'sd1 <<< 24);
	assign rdlon = pdlon_s2 + (60'sd1 <<< 24);
	assign rlata = plata_s2 + (60'sd1 <<< 23);
	assign rlatb = platb_s2 + (60'sd1 <<< 23);

	assign push             = vld_s2;
	assign push_data.p_dlat = rdlat[56:25];
	assign push_data.p_dlon = rdlon[56:25];
	assign push_data.p_lata = rlata[55:24];
	assign push_data.p_latb = rlatb[55:24];

endmodule

### design/hvd_sincos.sv
// ---------------------------------------------------------------------------
// Haversine sine and cosine unit
// Pipelined CORDIC rotation, one step per stage, with quadrant folding.
// ---------------------------------------------------------------------------
module hvd_sincos (
	input  logic               clk,
	input  logic               en,
	input  logic [31:0]        phase,
	output logic signed [31:0] cosine,
	output logic signed [31:0] sine
);
	localparam int unsigned N = hvd_pkg::CORDIC_STEPS;
	localparam logic signed [32:0] ONE = 33'sd1073741824;

	logic [31:0] biased, resid;
	logic [1:0]  quad;
	logic signed [32:0] x_s [0:N];
	logic signed [32:0] y_s [0:N];
	logic signed [31:0] z_s [0:N];
	logic [1:0]         q_s [0:N];
	logic signed [31:0] xc, yc;

	assign biased = phase + 32'h2000_0000;
	assign quad   = biased[31:30];
	assign resid  = phase - {quad, 30'b0};

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0] <= hvd_pkg::CORDIC_INV_GAIN;
			y_s[0] <= '0;
			z_s[0] <= resid;
			q_s[0] <= quad;
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_step
		localparam logic signed [31:0] ANG = {2'b00, hvd_pkg::atan_phase(i)};
		always_ff @(posedge clk) begin
			if (en) begin
				q_s[i+1] <= q_s[i];
				if (!z_s[i][31]) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - ANG;
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + ANG;
				end
			end
		end
	end

	always_comb begin
		if (x_s[N] > ONE) xc = 32'sd1073741824;
		else if (x_s[N] < -ONE) xc = -32'sd1073741824;
		else xc = x_s[N][31:0];
		if (y_s[N] > ONE) yc = 32'sd1073741824;
		else if (y_s[N] < -ONE) yc = -32'sd1073741824;
		else yc = y_s[N][31:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			case (q_s[N])
				2'd0: begin cosine <= xc;  sine <= yc;  end
				2'd1: begin cosine <= -yc; sine <= xc;  end
				2'd2: begin cosine <= -xc; sine <= -yc; end
				default: begin cosine <= yc; sine <= -xc; end
			endcase
		end
	end

endmodule

### design/hvd_isqrt.sv
// ---------------------------------------------------------------------------
// Haversine square root unit
// Pipelined digit-by-digit integer square root of the operand times 2^30.
// ---------------------------------------------------------------------------
module hvd_isqrt (
	input  logic                            clk,
	input  logic                            en,
	input  logic [hvd_pkg::ROOT_BITS-1:0]   operand,
	output logic [hvd_pkg::ROOT_BITS-1:0]   root
);
	localparam int unsigned RB = hvd_pkg::ROOT_BITS;

	logic [RB-1:0] op_s   [0:RB];
	logic [RB-1:0] root_s [0:RB];
	logic [32:0]   rem_s  [0:RB];

	always_ff @(posedge clk) begin
		if (en) begin
			op_s[0]   <= operand;
			root_s[0] <= '0;
			rem_s[0]  <= '0;
		end
	end

	for (genvar j = 0; j < RB; j++) begin : g_digit
		localparam int unsigned K = RB - 1 - j;
		logic [61:0] radicand;
		logic [34:0] rem_sh, trial;
		assign radicand = {1'b0, op_s[j], 30'b0};
		assign rem_sh   = {rem_s[j], radicand[2*K+1 -: 2]};
		assign trial    = {2'b00, root_s[j], 2'b01};
		always_ff @(posedge clk) begin
			if (en) begin
				op_s[j+1] <= op_s[j];
				if (rem_sh >= trial) begin
					rem_s[j+1]  <= 33'(rem_sh - trial);
					root_s[j+1] <= {root_s[j][RB-2:0], 1'b1};
				end else begin
					rem_s[j+1]  <= rem_sh[32:0];
					root_s[j+1] <= {root_s[j][RB-2:0], 1'b0};
				end
			end
		end
	end

	assign root = root_s[RB];

endmodule

### design/hvd_back.sv
// ---------------------------------------------------------------------------
// Haversine back end
// Trig, haversine term, roots, central angle and scaling to miles.
// ---------------------------------------------------------------------------
module hvd_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          queue_empty,
	input  hvd_pkg::phase_set_t           head,
	output logic                          pop,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [hvd_pkg::DIST_W-1:0]    distance
);
	localparam int unsigned L  = hvd_pkg::BACK_LAT;
	localparam int unsigned N  = hvd_pkg::CORDIC_STEPS;
	localparam int unsigned RB = hvd_pkg::ROOT_BITS;

	logic en;
	logic [L-1:0] vld_q;
	logic signed [31:0] s1, s2, ca, cb;
	logic signed [63:0] sq1_s1, sq2_s1, cc_s1;
	logic [30:0] s1sq_s2, s2sq_s2, s1sq_s3;
	logic signed [31:0] cc_s2;
	logic signed [62:0] p2_s3, p2r;
	logic signed [33:0] a_sum;
	logic [30:0] a_s4;
	logic [RB-1:0] root_a, root_c;
	logic signed [33:0] vx_s [1:N];
	logic signed [33:0] vy_s [1:N];
	logic signed [32:0] vz_s [1:N];
	logic [30:0] zc;
	logic [62:0] prod_s5;
	logic [63:0] rnd;
	logic [hvd_pkg::DIST_W-1:0] dist_s6;

	// The whole back pipeline advances together; the last stage is the output register.
	assign en       = !vld_q[L-1] || m_tready;
	assign pop      = en && !queue_empty;
	assign m_tvalid = vld_q[L-1];
	assign distance = dist_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[L-2:0], pop};
		end
	end

	hvd_sincos u_dlat (.clk(clk), .en(en), .phase(head.p_dlat), .cosine(), .sine(s1));
	hvd_sincos u_dlon (.clk(clk), .en(en), .phase(head.p_dlon), .cosine(), .sine(s2));
	hvd_sincos u_lata (.clk(clk), .en(en), .phase(head.p_lata), .cosine(ca), .sine());
	hvd_sincos u_latb (.clk(clk), .en(en), .phase(head.p_latb), .cosine(cb), .sine());

	always_ff @(posedge clk) begin
		if (en) begin
			sq1_s1  <= s1 * s1;
			sq2_s1  <= s2 * s2;
			cc_s1   <= ca * cb;
			s1sq_s2 <= 31'((sq1_s1 + 64'sd536870912) >>> 30);
			s2sq_s2 <= 31'((sq2_s1 + 64'sd536870912) >>> 30);
			cc_s2   <= 32'((cc_s1 + 64'sd536870912) >>> 30);
			p2_s3   <= cc_s2 * $signed({1'b0, s2sq_s2});
			s1sq_s3 <= s1sq_s2;
			a_s4    <= (a_sum[33]) ? 31'd0 :
			           (a_sum > 34'sd1073741824) ? 31'd1073741824 : a_sum[30:0];
		end
	end

	assign p2r   = p2_s3 + 63'sd536870912;
	assign a_sum = $signed({3'b000, s1sq_s3}) + $signed({p2r[62], p2r[62:30]});

	hvd_isqrt u_root_a (.clk(clk), .en(en), .operand(a_s4), .root(root_a));
	hvd_isqrt u_root_c (.clk(clk), .en(en), .operand(31'd1073741824 - a_s4), .root(root_c));

	// Vectoring CORDIC drives y towards zero; z gathers the angle atan2(y, x).
	for (genvar i = 0; i < N; i++) begin : g_vec
		localparam logic signed [32:0] ANG = {3'b000, hvd_pkg::atan_phase(i)};
		logic signed [33:0] xi, yi;
		logic signed [32:0] zi;
		if (i == 0) begin : g_first
			assign xi = {3'b000, root_c};
			assign yi = {3'b000, root_a};
			assign zi = '0;
		end else begin : g_rest
			assign xi = vx_s[i];
			assign yi = vy_s[i];
			assign zi = vz_s[i];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				if (!yi[33] && (yi != '0)) begin
					vx_s[i+1] <= xi + (yi >>> i);
					vy_s[i+1] <= yi - (xi >>> i);
					vz_s[i+1] <= zi + ANG;
				end else begin
					vx_s[i+1] <= xi - (yi >>> i);
					vy_s[i+1] <= yi + (xi >>> i);
					vz_s[i+1] <= zi - ANG;
				end
			end
		end
	end

	always_comb begin
		if (vz_s[N][32]) zc = '0;
		else if (vz_s[N] > 33'sd1073741824) zc = 31'd1073741824;
		else zc = vz_s[N][30:0];
	end

	assign rnd = {1'b0, prod_s5} + 64'h8000_0000;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s5 <= zc * hvd_pkg::DIST_SCALE;
			dist_s6 <= rnd[61:32];
		end
	end

endmodule
